>>> hdl/hlt_pkg.sv
package hlt_pkg;

  // Field and counter widths fixed by the block's interface
  localparam int TIME_W = 32;
  localparam int AVG_W  = 16;
  localparam int CMD_W  = 2;

  // Parameter defaults
  localparam int DEF_MAX_BEATS = 32;
  localparam int DEF_ID_BITS   = 17;

  // Reset value of the alive limit
  localparam logic [AVG_W-1:0] LIMIT_RESET = 16'd1000;

  // Input command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_ACK   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_DONE
  } state_t;

  // Per-beat control broadcast to every cell
  typedef struct packed {
    logic send;
    logic ack;
  } cell_ctl_t;

endpackage

>>> hdl/hlt_cell.sv
module hlt_cell #(
  parameter int ID_BITS = 17,
  parameter int SUM_W   = 37,
  parameter int CNT_W   = 6,
  parameter int SLOT_W  = 5,
  parameter int IDX     = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  hlt_pkg::cell_ctl_t        ctl,
  input  logic [SLOT_W-1:0]         slot,
  input  logic [ID_BITS-1:0]        id_in,
  input  logic [hlt_pkg::TIME_W-1:0] now_ms,
  input  logic [SUM_W-1:0]          sum_in,
  input  logic [CNT_W-1:0]          cnt_in,
  output logic [SUM_W-1:0]          sum_out,
  output logic [CNT_W-1:0]          cnt_out
);
  import hlt_pkg::*;

  logic               valid;
  logic               done;
  logic [ID_BITS-1:0] id;
  logic [TIME_W-1:0]  start;
  logic [TIME_W-1:0]  latency;
  logic [TIME_W-1:0]  contrib;
  logic [TIME_W-1:0]  elapsed;
  logic               hit;
  logic               match;

  assign elapsed = now_ms - start;
  assign hit     = ctl.send && (slot == SLOT_W'(IDX));
  assign match   = ctl.ack && valid && !done && (id == id_in);

  // Track occupancy and completion
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      done  <= 1'b0;
    end else if (hit) begin
      valid <= 1'b1;
      done  <= 1'b0;
    end else if (match) begin
      done <= 1'b1;
    end
  end

  // Store entry payload
  always_ff @(posedge clk) begin
    if (hit) begin
      id    <= id_in;
      start <= now_ms;
    end
    if (match) begin
      latency <= elapsed;
    end
  end

  // Register this entry's share, then add it onto the running sum
  always_ff @(posedge clk) begin
    if (!valid) begin
      contrib <= '0;
    end else if (done) begin
      contrib <= latency;
    end else begin
      contrib <= elapsed;
    end
    sum_out <= sum_in + SUM_W'(contrib);
    cnt_out <= cnt_in + CNT_W'(valid);
  end

endmodule

>>> hdl/hlt_divider.sv
module hlt_divider #(
  parameter int SUM_W = 37,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);
  import hlt_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [SUM_W-1:0]  dvd;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    rem_sh;
  logic              qbit;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh   = {rem, dvd[SUM_W-1]};
  assign qbit     = (rem_sh >= {1'b0, dsr});
  assign quotient = dvd;

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[SUM_W-2:0], qbit};
      rem <= qbit ? CNT_W'(rem_sh - {1'b0, dsr}) : rem_sh[CNT_W-1:0];
    end
  end

endmodule

>>> hdl/heartbeat_latency_tracker_core.sv
// Heartbeat latency tracker.
// Input channel (in_valid / in_stall) carries one command beat: tick advances
// the millisecond counter, send stores beat_id with the current time in the
// next ring slot (overwriting the oldest once full), ack completes every
// pending entry with that id, query asks for the mean latency.
// Output channel (out_valid / out_stall) carries one beat per query:
// avg_latency_ms (truncated, saturated at 65535, 0 on an empty table) and
// alive (average below alive_limit_ms). cfg_we / cfg_wdata set the limit.
// Tick, send and ack leave the input free; a new beat may follow at once.
// A query runs its sum down the row of MAX_BEATS cells, then a restoring
// divider takes one quotient bit per cycle over the 32 + clog2(MAX_BEATS)
// bit sum; the result is registered once the output register is free,
// and the next beat is taken once the sequencer is back in idle.
// Reset clears the counter, the ring pointer, all entries and the output,
// and sets the limit to 1000. While a result waits under out_stall the next
// command is still taken; a following query finishes and holds its result
// until the output register frees up.
module heartbeat_latency_tracker_core #(
  parameter int MAX_BEATS = hlt_pkg::DEF_MAX_BEATS,
  parameter int ID_BITS   = hlt_pkg::DEF_ID_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [hlt_pkg::CMD_W-1:0]  cmd,
  input  logic [ID_BITS-1:0]         beat_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hlt_pkg::AVG_W-1:0]  avg_latency_ms,
  output logic                       alive,
  input  logic                       cfg_we,
  input  logic [hlt_pkg::AVG_W-1:0]  cfg_wdata
);
  import hlt_pkg::*;

  localparam int SLOT_W  = $clog2(MAX_BEATS);
  localparam int SUM_W   = TIME_W + $clog2(MAX_BEATS);
  localparam int CNT_W   = $clog2(MAX_BEATS + 1);
  localparam int WAIT_W  = $clog2(MAX_BEATS + 2);
  localparam logic [WAIT_W-1:0] SUM_WAIT = WAIT_W'(MAX_BEATS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_BEATS - 1);

  state_t              state;
  state_t              state_next;
  logic [WAIT_W-1:0]   sum_cnt;
  logic [TIME_W-1:0]   now_ms;
  logic [SLOT_W-1:0]   insert_slot;
  logic [AVG_W-1:0]    alive_limit_ms;
  logic [AVG_W-1:0]    avg_hold;
  logic                cnt_zero;
  logic                in_acc;
  logic                out_free;
  logic                div_start;
  logic                div_done;
  logic                out_load;
  logic [SUM_W-1:0]    quotient;
  cmd_t                cmd_code;
  cell_ctl_t           ctl;
  logic [SUM_W-1:0]    sum_chain [MAX_BEATS+1];
  logic [CNT_W-1:0]    cnt_chain [MAX_BEATS+1];

  assign cmd_code = cmd_t'(cmd);
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign ctl.send = in_acc && (cmd_code == CMD_SEND);
  assign ctl.ack  = in_acc && (cmd_code == CMD_ACK);

  // Row of entry cells, summing from cell 0 toward the last
  assign sum_chain[0] = '0;
  assign cnt_chain[0] = '0;
  for (genvar g = 0; g < MAX_BEATS; g++) begin : g_cell
    hlt_cell #(
      .ID_BITS(ID_BITS),
      .SUM_W  (SUM_W),
      .CNT_W  (CNT_W),
      .SLOT_W (SLOT_W),
      .IDX    (g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .slot   (insert_slot),
      .id_in  (beat_id),
      .now_ms (now_ms),
      .sum_in (sum_chain[g]),
      .cnt_in (cnt_chain[g]),
      .sum_out(sum_chain[g+1]),
      .cnt_out(cnt_chain[g+1])
    );
  end

  hlt_divider #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum_chain[MAX_BEATS]),
    .divisor (cnt_chain[MAX_BEATS]),
    .done    (div_done),
    .quotient(quotient)
  );

  // Advance the clock and the ring pointer, hold the limit
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms         <= '0;
      insert_slot    <= '0;
      alive_limit_ms <= LIMIT_RESET;
    end else begin
      if (in_acc && (cmd_code == CMD_TICK)) begin
        now_ms <= now_ms + 1'b1;
      end
      if (ctl.send) begin
        insert_slot <= (insert_slot == LAST_SLOT) ? '0 : insert_slot + 1'b1;
      end
      if (cfg_we) begin
        alive_limit_ms <= cfg_wdata;
      end
    end
  end

  // State register and settle counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sum_cnt <= '0;
    end else begin
      state   <= state_next;
      sum_cnt <= (state == S_SUM) ? sum_cnt + 1'b1 : '0;
    end
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_acc && (cmd_code == CMD_QUERY)) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (sum_cnt == SUM_WAIT) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Capture the empty flag and the saturated quotient
  always_ff @(posedge clk) begin
    if (div_start) begin
      cnt_zero <= (cnt_chain[MAX_BEATS] == '0);
    end
    if (div_done) begin
      if (cnt_zero) begin
        avg_hold <= '0;
      end else if (|quotient[SUM_W-1:AVG_W]) begin
        avg_hold <= '1;
      end else begin
        avg_hold <= quotient[AVG_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_latency_ms <= avg_hold;
      alive          <= (avg_hold < alive_limit_ms);
    end
  end

endmodule

>>> hdl/hlt_checker.sv
module hlt_checker #(
  parameter int ID_BITS = hlt_pkg::DEF_ID_BITS
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [hlt_pkg::CMD_W-1:0] cmd,
  input logic [ID_BITS-1:0]        beat_id,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [hlt_pkg::AVG_W-1:0] avg_latency_ms,
  input logic                      alive,
  input logic                      cfg_we,
  input logic [hlt_pkg::AVG_W-1:0] cfg_wdata
);
  import hlt_pkg::*;

  logic [AVG_W-1:0] limit;
  logic             in_acc;

  assign in_acc = in_valid && !in_stall;

  // Mirror the limit register from the port
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(avg_latency_ms) && $stable(alive))
    else $error("result beat changed under stall");

  // Alive agrees with the average and the limit
  a_alive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (alive == (avg_latency_ms < limit)))
    else $error("alive flag disagrees with average");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat after reset");

  // A query blocks the next command
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && (cmd == CMD_QUERY) |=> in_stall)
    else $error("command taken during query");

  // Other commands produce no result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_acc && (cmd != CMD_QUERY) && !out_valid |=> !out_valid)
    else $error("result beat without a query");

endmodule

bind heartbeat_latency_tracker_core hlt_checker #(.ID_BITS(ID_BITS)) u_hlt_checker (.*);

>>> bench/heartbeat_latency_tracker_core_test.sv
`timescale 1ns / 100ps

module heartbeat_latency_tracker_core_test;
  import hlt_pkg::*;

  localparam int NBEATS         = DEF_MAX_BEATS;
  localparam int ID_W           = DEF_ID_BITS;
  localparam int ID_MAX         = (1 << ID_W) - 1;
  localparam int QUIET_CYCLES   = 90;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int AGE_TICKS      = 60;
  localparam int CYCLE_LIMIT    = 2000000;

  typedef struct packed {
    logic [AVG_W-1:0] avg_ms;
    logic             alive;
  } latency_report_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  cmd_t             beat_cmd;
  logic [ID_W-1:0]  beat_id;
  logic             out_valid;
  logic             out_stall;
  logic [AVG_W-1:0] avg_latency_ms;
  logic             alive;
  logic             cfg_we;
  logic [AVG_W-1:0] cfg_wdata;

  // Predicted tracker state
  logic [TIME_W-1:0] now_ms;
  logic [ID_W-1:0]   slot_id[NBEATS];
  logic [TIME_W-1:0] slot_start[NBEATS];
  logic [TIME_W-1:0] slot_latency[NBEATS];
  logic              slot_done[NBEATS];
  logic              slot_valid[NBEATS];
  int unsigned       ins_slot;
  logic [AVG_W-1:0]  alive_limit;

  latency_report_t   pending_reports[$];

  // Recently sent ids, so acks hit live entries
  logic [ID_W-1:0]   recent_ids[8];
  int unsigned       recent_wr;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_seq;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned reports_checked;
  int unsigned saturated_seen;
  int unsigned dead_seen;

  heartbeat_latency_tracker_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (beat_cmd),
    .beat_id        (beat_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .avg_latency_ms (avg_latency_ms),
    .alive          (alive),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the predicted state by one accepted beat; queue a report for a query
  function automatic void track_beat(input cmd_t c, input logic [ID_W-1:0] id);
    logic [63:0]       total;
    logic [63:0]       mean;
    logic [TIME_W-1:0] elapsed;
    int unsigned       live;
    latency_report_t   rep;
    case (c)
      CMD_TICK: begin
        now_ms = now_ms + 1;
      end
      CMD_SEND: begin
        slot_id[ins_slot]      = id;
        slot_start[ins_slot]   = now_ms;
        slot_latency[ins_slot] = '0;
        slot_done[ins_slot]    = 1'b0;
        slot_valid[ins_slot]   = 1'b1;
        ins_slot = (ins_slot + 1) % NBEATS;
      end
      CMD_ACK: begin
        for (int i = 0; i < NBEATS; i++) begin
          if (slot_valid[i] && !slot_done[i] && slot_id[i] == id) begin
            slot_done[i]    = 1'b1;
            slot_latency[i] = now_ms - slot_start[i];
          end
        end
      end
      default: begin
        total = '0;
        live  = 0;
        for (int i = 0; i < NBEATS; i++) begin
          if (slot_valid[i]) begin
            elapsed = slot_done[i] ? slot_latency[i] : now_ms - slot_start[i];
            total   = total + elapsed;
            live++;
          end
        end
        mean = (live == 0) ? 64'd0 : total / live;
        rep.avg_ms = (mean > 64'd65535) ? 16'hFFFF : mean[AVG_W-1:0];
        rep.alive  = rep.avg_ms < alive_limit;
        pending_reports.push_back(rep);
      end
    endcase
  endfunction

  // Offer one beat, hold it until taken, then update the prediction
  task automatic send_beat(input cmd_t c, input logic [ID_W-1:0] id);
    logic taken;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    beat_cmd <= c;
    beat_id  <= id;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    track_beat(c, id);
    items_sent++;
  endtask

  // Drop valid and wait until the block has nothing left in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_alive_limit(input logic [AVG_W-1:0] limit);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    alive_limit = limit;
  endtask

  function automatic logic [ID_W-1:0] pick_send_id();
    // Half from a tiny pool to force duplicate ids
    if ($urandom_range(1) == 0) return ID_W'($urandom_range(15));
    return ID_W'($urandom_range(ID_MAX));
  endfunction

  task automatic random_beats(input int unsigned count);
    int unsigned      roll;
    logic [ID_W-1:0]  id;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 38) begin
        send_beat(CMD_TICK, ID_W'($urandom_range(ID_MAX)));
      end else if (roll < 58) begin
        id = pick_send_id();
        recent_ids[recent_wr] = id;
        recent_wr = (recent_wr + 1) % 8;
        send_beat(CMD_SEND, id);
      end else if (roll < 80) begin
        id = ($urandom_range(99) < 70) ? recent_ids[3'($urandom_range(7))] : pick_send_id();
        send_beat(CMD_ACK, id);
      end else begin
        send_beat(CMD_QUERY, ID_W'($urandom_range(ID_MAX)));
      end
    end
  endtask

  // Empty table: average is zero, alive follows the limit alone
  task automatic test_empty_table();
    send_beat(CMD_QUERY, '0);
    set_alive_limit(16'd0);
    send_beat(CMD_QUERY, ID_W'(ID_MAX));
    set_alive_limit(16'hFFFF);
    send_beat(CMD_QUERY, '0);
    set_alive_limit(LIMIT_RESET);
  endtask

  // Extreme ids, repeated and unmatched acks, duplicate pending ids
  task automatic test_directed();
    tx_idle_pct = 22;
    rx_idle_pct = 52;
    send_beat(CMD_SEND, '0);
    send_beat(CMD_SEND, ID_W'(ID_MAX));
    repeat (3) send_beat(CMD_TICK, '0);
    send_beat(CMD_ACK, ID_W'(ID_MAX));
    send_beat(CMD_ACK, ID_W'(ID_MAX));
    send_beat(CMD_TICK, ID_W'(ID_MAX));
    send_beat(CMD_ACK, ID_W'(77));
    send_beat(CMD_QUERY, '0);
    send_beat(CMD_SEND, ID_W'(ID_MAX));
    send_beat(CMD_SEND, '0);
    repeat (2) send_beat(CMD_TICK, '0);
    send_beat(CMD_ACK, '0);
    send_beat(CMD_QUERY, ID_W'(ID_MAX));
  endtask

  task automatic test_random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                                   input int unsigned count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    random_beats(count);
  endtask

  // Hold the output off long enough that queries back up into the input
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_seq++;
    repeat (8) send_beat(CMD_QUERY, ID_W'($urandom_range(ID_MAX)));
    settle();
    random_beats(20);
  endtask

  // Refill the whole table, let the pending entries age, then ack half of them
  task automatic test_full_table();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_alive_limit(16'hFFFF);
    for (int i = 0; i < NBEATS; i++) send_beat(CMD_SEND, ID_W'(1000 + i));
    repeat (AGE_TICKS) send_beat(CMD_TICK, '0);
    send_beat(CMD_QUERY, '0);
    for (int i = 0; i < NBEATS / 2; i++) send_beat(CMD_ACK, ID_W'(1000 + i));
    repeat (5) send_beat(CMD_TICK, '0);
    send_beat(CMD_QUERY, '0);
    set_alive_limit(16'd0);
    send_beat(CMD_QUERY, '0);
  endtask

  // Drive the receiver stall: random, or a counted hold-off on request
  initial begin
    int unsigned seen_seq;
    int unsigned hold_left;
    seen_seq  = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Compare each accepted result beat with the oldest predicted report
  initial begin
    latency_report_t want;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result beat: avg %0d alive %0b", avg_latency_ms, alive);
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          reports_checked++;
          if (avg_latency_ms == 16'hFFFF) saturated_seen++;
          if (!alive) dead_seen++;
          if (avg_latency_ms !== want.avg_ms) begin
            if (mismatch_count < 10)
              $display("avg_latency_ms mismatch: expected %0d, got %0d",
                       want.avg_ms, avg_latency_ms);
            mismatch_count++;
          end
          if (alive !== want.alive) begin
            if (mismatch_count < 10)
              $display("alive mismatch: expected %0b, got %0b", want.alive, alive);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("[heartbeat_latency_tracker_core] ERROR");
    $finish;
  end

  initial begin
    now_ms          = '0;
    ins_slot        = 0;
    alive_limit     = LIMIT_RESET;
    recent_wr       = 0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    hold_seq        = 0;
    mismatch_count  = 0;
    items_sent      = 0;
    reports_checked = 0;
    saturated_seen  = 0;
    dead_seen       = 0;
    for (int i = 0; i < NBEATS; i++) begin
      slot_done[i]  = 1'b0;
      slot_valid[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) recent_ids[i] = '0;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    beat_cmd  <= CMD_TICK;
    beat_id   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_directed();
    test_random_phase(22, 52, 600);
    set_alive_limit(16'($urandom_range(10, 200)));
    test_random_phase(52, 22, 600);
    set_alive_limit(16'($urandom_range(10, 200)));
    test_random_phase(0, 0, 600);
    test_backpressure();
    test_full_table();

    rx_idle_pct = 0;
    settle();

    $display("ran %0d beats over %0d cycles; %0d latency reports checked",
             items_sent, cycle_count, reports_checked);
    $display("%0d reports saturated, %0d reported not alive, %0d mismatches",
             saturated_seen, dead_seen, mismatch_count);
    if (mismatch_count == 0)
      $display("[heartbeat_latency_tracker_core] OK");
    else
      $display("[heartbeat_latency_tracker_core] ERROR");
    $finish;
  end

endmodule
